@@ rtl/shortest_job_first_scheduler_core_defines.svh @@
// Assertion macros for the scheduler core.
// Included by modules that carry concurrent checks; expects clk and arst_n in scope.
`ifndef SHORTEST_JOB_FIRST_SCHEDULER_CORE_DEFINES_SVH
`define SHORTEST_JOB_FIRST_SCHEDULER_CORE_DEFINES_SVH

// condition holds at every edge out of reset
`define SJF_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SJF_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/sjf_pkg.sv @@
// Shared types, constants and helpers for the scheduler core.
// No dependencies.
package sjf_pkg;

	localparam int SLOTS      = 8;
	localparam int MAX_BURSTS = 32;
	localparam int SLOT_W     = 3;
	localparam int PTR_W      = $clog2(MAX_BURSTS);
	localparam int CNT_W      = $clog2(MAX_BURSTS + 1);
	localparam int LEN_W      = $clog2(SLOTS + 1);
	localparam int ADDR_W     = SLOT_W + PTR_W;
	localparam int STORE_D    = SLOTS * MAX_BURSTS;
	localparam int VAL_W      = 8;
	localparam int CNT16_W    = 16;
	localparam int TURN_W     = 18;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 88;

	localparam logic KIND_FINISH = 1'b0;
	localparam logic KIND_REJECT = 1'b1;
	localparam logic MODE_LOAD   = 1'b0;

	typedef enum logic [2:0] {
		PL_EMPTY, PL_LOADING, PL_READY, PL_RUNNING, PL_IO, PL_FINISHED
	} place_t;

	typedef struct packed {
		logic latch;
		logic load_wr;
		logic reject;
		logic scan_start;
		logic scan_step;
		logic pick;
		logic step;
		logic chk_rd;
		logic finish;
		logic io_wr;
	} cmd_t;

	typedef struct packed {
		logic is_tick;
		logic load_bad;
		logic can_pick;
		logic scan_done;
		logic cpu_end;
		logic has_next;
		logic out_free;
	} stat_t;

	function automatic logic [CNT16_W-1:0] sat_inc(input logic [CNT16_W-1:0] v);
		sat_inc = (v == '1) ? v : v + 1'b1;
	endfunction

endpackage

@@ rtl/shortest_job_first_scheduler_core.sv @@
// Non-preemptive shortest-job-first scheduler core; one item in flight at a time.
// A load passes through decode only; a tick passes through decode, step and check, with scan
// and pick between decode and step when the idle CPU picks a slot (scan reads one burst a cycle),
// plus an I/O write state when the running slot enters I/O.
// A reject is registered from the decode state and a finish record from the check state;
// a second result waits for the first.
module shortest_job_first_scheduler_core import sjf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // [2:0] slot, [10:3] phase_value, rest zero
	input  logic                  s_tuser,  // mode
	input  logic                  s_tlast,  // phase_last
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // done_slot, wait_total, response, cpu_ticks,
	                                        // io_ticks, turnaround, all_finished, zero pad
	output logic                  m_tuser   // kind
);
	// Reset (arst_n, asynchronous, active low) empties all slots and the ready list.
	cmd_t  cmd;
	stat_t st;
	logic  in_fire;

	// an input transfer completes only while the sequencer is idle
	assign in_fire = s_tvalid && s_tready;

	sjf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_rdy(s_tready),
		.st(st), .cmd(cmd)
	);

	// datapath holds all slot state plus the output register
	sjf_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.in_mode(s_tuser), .in_slot(s_tdata[SLOT_W-1:0]),
		.in_val(s_tdata[SLOT_W+VAL_W-1:SLOT_W]), .in_last(s_tlast),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_kind(m_tuser), .out_data(m_tdata)
	);
endmodule

@@ rtl/sjf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sjf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

@@ rtl/sjf_ctrl.sv @@
// Sequencer for the scheduler core: walks one load or tick through its steps.
// Depends on sjf_pkg.
module sjf_ctrl import sjf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_fire,
	output logic  in_rdy,
	input  stat_t st,
	output cmd_t  cmd
);
	typedef enum logic [2:0] {
		S_IDLE, S_DECODE, S_SCAN, S_PICK, S_STEP, S_CHK, S_IOWR
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_fire) state_q <= S_DECODE;
				S_DECODE: begin
					if (!st.is_tick) begin
						if (!st.load_bad || st.out_free) state_q <= S_IDLE;
					end else if (st.can_pick) begin
						state_q <= S_SCAN;
					end else begin
						state_q <= S_STEP;
					end
				end
				S_SCAN: if (st.scan_done) state_q <= S_PICK;
				S_PICK: state_q <= S_STEP;
				S_STEP: state_q <= S_CHK;
				S_CHK: begin
					if (!st.cpu_end) state_q <= S_IDLE;
					else if (st.has_next) state_q <= S_IOWR;
					else if (st.out_free) state_q <= S_IDLE;
				end
				S_IOWR: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		in_rdy = (state_q == S_IDLE);
		cmd.latch = in_fire;
		case (state_q)
			S_DECODE: begin
				cmd.load_wr    = !st.is_tick && !st.load_bad;
				cmd.reject     = !st.is_tick && st.load_bad && st.out_free;
				cmd.scan_start = st.is_tick && st.can_pick;
			end
			S_SCAN:  cmd.scan_step = 1'b1;
			S_PICK:  cmd.pick = 1'b1;
			S_STEP:  cmd.step = 1'b1;
			S_CHK: begin
				cmd.chk_rd = st.cpu_end && st.has_next;
				cmd.finish = st.cpu_end && !st.has_next && st.out_free;
			end
			S_IOWR:  cmd.io_wr = 1'b1;
			default: ;
		endcase
	end
endmodule

@@ rtl/sjf_dp.sv @@
// Datapath of the scheduler core: per-slot state, ready list, burst store, result register.
// Depends on sjf_pkg, sjf_ram and the assertion macro header.
`include "shortest_job_first_scheduler_core_defines.svh"
module sjf_dp import sjf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output stat_t                 st,
	input  logic                  in_mode,
	input  logic [SLOT_W-1:0]     in_slot,
	input  logic [VAL_W-1:0]      in_val,
	input  logic                  in_last,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  out_kind,
	output logic [OUT_DATA_W-1:0] out_data
);
	logic              mode_q, last_q;
	logic [SLOT_W-1:0] slot_q;
	logic [VAL_W-1:0]  val_q;

	logic [CNT_W-1:0]   cnt_q   [SLOTS];
	logic [CNT_W-1:0]   ptr_q   [SLOTS];
	place_t             place_q [SLOTS];
	logic [VAL_W-1:0]   iol_q   [SLOTS];
	logic [CNT16_W-1:0] wait_q  [SLOTS];
	logic [CNT16_W-1:0] resp_q  [SLOTS];
	logic [CNT16_W-1:0] cpuc_q  [SLOTS];
	logic [CNT16_W-1:0] ioc_q   [SLOTS];
	logic [SLOTS-1:0]   ran_q;
	logic [SLOT_W-1:0]  ready_q [SLOTS];
	logic [LEN_W-1:0]   rlen_q;
	logic [SLOT_W-1:0]  rs_q;
	logic [VAL_W-1:0]   cpul_q;
	logic               busy_q;

	logic [LEN_W-1:0]  idx_q, cidx_q;
	logic              cval_q;
	logic [LEN_W-1:0]  best_q;
	logic [VAL_W-1:0]  bval_q;

	logic                  ov_q, okind_q;
	logic [OUT_DATA_W-1:0] odata_q;

	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic [VAL_W-1:0]  rdata;
	logic              issue;
	logic [SLOT_W-1:0] scan_slot;

	sjf_ram #(.WIDTH(VAL_W), .DEPTH(STORE_D)) u_store (
		.clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(val_q),
		.rd_addr(rd_addr), .rd_data(rdata)
	);

	assign wr_en     = cmd.load_wr;
	assign wr_addr   = {slot_q, cnt_q[slot_q][PTR_W-1:0]};
	assign scan_slot = ready_q[idx_q[SLOT_W-1:0]];
	assign issue     = cmd.scan_step && (idx_q < rlen_q);
	assign rd_addr   = cmd.chk_rd ? {rs_q, ptr_q[rs_q][PTR_W-1:0]}
	                              : {scan_slot, ptr_q[scan_slot][PTR_W-1:0]};

	// status
	logic other_busy;
	always_comb begin
		other_busy = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			if (SLOT_W'(i) != rs_q &&
			    (place_q[i] == PL_READY || place_q[i] == PL_RUNNING || place_q[i] == PL_IO))
				other_busy = 1'b1;
		end
		st.is_tick   = (mode_q != MODE_LOAD);
		st.load_bad  = (int'(slot_q) >= SLOTS) ||
		               (place_q[slot_q] != PL_EMPTY && place_q[slot_q] != PL_LOADING) ||
		               (cnt_q[slot_q] >= CNT_W'(MAX_BURSTS)) || (val_q == '0) ||
		               (last_q && cnt_q[slot_q][0]);
		st.can_pick  = !busy_q && (rlen_q != '0);
		st.scan_done = cval_q && (cidx_q == rlen_q - 1'b1);
		st.cpu_end   = busy_q && (cpul_q == '0);
		st.has_next  = ptr_q[rs_q] < cnt_q[rs_q];
		st.out_free  = !ov_q || out_ready;
	end

	// I/O completions join the ready list in ascending slot order
	logic [SLOT_W-1:0] nready [SLOTS];
	logic [LEN_W-1:0]  nlen;
	logic [SLOTS-1:0]  joins;
	always_comb begin
		nready = ready_q;
		nlen   = rlen_q;
		joins  = '0;
		for (int s = 0; s < SLOTS; s++) begin
			if (place_q[s] == PL_IO && iol_q[s] <= VAL_W'(1)) begin
				joins[s] = 1'b1;
				if (nlen < LEN_W'(SLOTS)) begin
					nready[nlen[SLOT_W-1:0]] = SLOT_W'(s);
					nlen = nlen + 1'b1;
				end
			end
		end
	end

	logic [SLOT_W-1:0] pick_slot;
	assign pick_slot = ready_q[best_q[SLOT_W-1:0]];

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			mode_q <= in_mode;
			slot_q <= in_slot;
			val_q  <= in_val;
			last_q <= in_last;
		end
		if (cmd.reject) begin
			okind_q <= KIND_REJECT;
			odata_q <= {{(OUT_DATA_W-SLOT_W){1'b0}}, slot_q};
		end else if (cmd.finish) begin
			okind_q <= KIND_FINISH;
			odata_q <= {2'b00, !other_busy,
			            TURN_W'(wait_q[rs_q]) + TURN_W'(cpuc_q[rs_q]) + TURN_W'(ioc_q[rs_q]),
			            ioc_q[rs_q], cpuc_q[rs_q], resp_q[rs_q], wait_q[rs_q], rs_q};
		end
		if (cmd.scan_start) begin
			idx_q  <= '0;
			cval_q <= 1'b0;
		end else if (cmd.scan_step) begin
			if (issue) idx_q <= idx_q + 1'b1;
			cval_q <= issue;
			cidx_q <= idx_q;
			if (cval_q && (cidx_q == '0 || rdata < bval_q)) begin
				bval_q <= rdata;
				best_q <= cidx_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SLOTS; s++) begin
				cnt_q[s]   <= '0;
				ptr_q[s]   <= '0;
				place_q[s] <= PL_EMPTY;
				iol_q[s]   <= '0;
				wait_q[s]  <= '0;
				resp_q[s]  <= '0;
				cpuc_q[s]  <= '0;
				ioc_q[s]   <= '0;
			end
			ran_q  <= '0;
			rlen_q <= '0;
			rs_q   <= '0;
			cpul_q <= '0;
			busy_q <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			if (cmd.reject || cmd.finish) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;

			if (cmd.load_wr) begin
				cnt_q[slot_q] <= cnt_q[slot_q] + 1'b1;
				if (last_q) begin
					place_q[slot_q] <= PL_READY;
					if (rlen_q < LEN_W'(SLOTS)) begin
						ready_q[rlen_q[SLOT_W-1:0]] <= slot_q;
						rlen_q <= rlen_q + 1'b1;
					end
				end else begin
					place_q[slot_q] <= PL_LOADING;
				end
			end

			if (cmd.pick) begin
				for (int i = 0; i < SLOTS - 1; i++) begin
					if (LEN_W'(i) >= best_q) ready_q[i] <= ready_q[i+1];
				end
				rlen_q <= rlen_q - 1'b1;
				if (!ran_q[pick_slot]) begin
					resp_q[pick_slot] <= wait_q[pick_slot];
					ran_q[pick_slot]  <= 1'b1;
				end
				cpul_q <= bval_q;
				if (ptr_q[pick_slot] < CNT_W'(MAX_BURSTS))
					ptr_q[pick_slot] <= ptr_q[pick_slot] + 1'b1;
				rs_q   <= pick_slot;
				busy_q <= 1'b1;
				place_q[pick_slot] <= PL_RUNNING;
			end

			if (cmd.step) begin
				if (busy_q) begin
					if (cpul_q != '0) cpul_q <= cpul_q - 1'b1;
					cpuc_q[rs_q] <= sat_inc(cpuc_q[rs_q]);
				end
				for (int s = 0; s < SLOTS; s++) begin
					if (place_q[s] == PL_IO) begin
						if (iol_q[s] != '0) iol_q[s] <= iol_q[s] - 1'b1;
						ioc_q[s] <= sat_inc(ioc_q[s]);
					end
					if (joins[s]) place_q[s] <= PL_READY;
					if (joins[s] || place_q[s] == PL_READY) wait_q[s] <= sat_inc(wait_q[s]);
				end
				ready_q <= nready;
				rlen_q  <= nlen;
			end

			if (cmd.chk_rd) ptr_q[rs_q] <= ptr_q[rs_q] + 1'b1;
			if (cmd.io_wr) begin
				iol_q[rs_q]   <= rdata;
				place_q[rs_q] <= PL_IO;
				busy_q        <= 1'b0;
			end
			if (cmd.finish) begin
				place_q[rs_q] <= PL_FINISHED;
				busy_q        <= 1'b0;
			end
		end
	end

	assign out_valid = ov_q;
	assign out_kind  = okind_q;
	assign out_data  = odata_q;

	logic [SLOTS-1:0] rdy_vec;
	logic             ptr_ok;
	always_comb begin
		ptr_ok = 1'b1;
		for (int s = 0; s < SLOTS; s++) begin
			rdy_vec[s] = (place_q[s] == PL_READY);
			if (ptr_q[s] > cnt_q[s]) ptr_ok = 1'b0;
		end
	end

	`SJF_ASSERT(a_rlen_bound, rlen_q <= LEN_W'(SLOTS), "ready list longer than slot count")
	`SJF_ASSERT(a_rlen_match, $countones(rdy_vec) == int'(rlen_q), "ready list out of step")
	`SJF_ASSERT(a_ptr_bound, ptr_ok, "burst pointer past list end")
	`SJF_IMPLY(a_busy_run, busy_q, place_q[rs_q] == PL_RUNNING, "busy CPU without running slot")
endmodule

@@ bench/shortest_job_first_scheduler_core_tb.sv @@
// Self-checking bench for the shortest-job-first scheduler core.
// Holds its own scheduler model; depends on sjf_pkg and the core RTL.
`timescale 1ns / 100ps

module shortest_job_first_scheduler_core_tb import sjf_pkg::*; ();

	localparam int RAND_SLOTS = 6;          // slots 0..5 carry the random workload
	localparam int LIMIT      = 1500000;
	localparam int EXP_D      = 256;

	typedef struct {
		logic               kind;
		logic [SLOT_W-1:0]  slot;
		logic [CNT16_W-1:0] wait_t;
		logic [CNT16_W-1:0] resp;
		logic [CNT16_W-1:0] cpu;
		logic [CNT16_W-1:0] io;
		logic [TURN_W-1:0]  turn;
		logic               all_fin;
	} rec_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready, s_tuser, s_tlast;
	logic [IN_DATA_W-1:0] s_tdata;
	logic m_tvalid, m_tready, m_tuser;
	logic [OUT_DATA_W-1:0] m_tdata;

	// scheduler model state
	logic [VAL_W-1:0]   bstore [SLOTS][MAX_BURSTS];
	int                 bcnt [SLOTS];
	int                 bptr [SLOTS];
	place_t             place [SLOTS];
	logic [VAL_W-1:0]   io_rem [SLOTS];
	logic [CNT16_W-1:0] waitc [SLOTS], respc [SLOTS], cpuc [SLOTS], ioc [SLOTS];
	logic               ran [SLOTS];
	int                 rdy [SLOTS];
	int                 rlen, run_slot;
	logic [VAL_W-1:0]   cpu_rem;
	logic               cpu_on;

	// expected records, oldest at exp_rd
	rec_t exp_mem [EXP_D];
	int   exp_wr, exp_rd;
	int   errors, cycles, items;
	bit   idle_en;
	int   long_hold;
	int   stall;

	shortest_job_first_scheduler_core u_top (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic logic [CNT16_W-1:0] sat16(input logic [CNT16_W-1:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic logic [VAL_W-1:0] next_len(input int s);
		return (bptr[s] >= MAX_BURSTS) ? '0 : bstore[s][bptr[s]];
	endfunction

	task automatic exp_put(input rec_t r);
		exp_mem[exp_wr % EXP_D] = r;
		exp_wr++;
	endtask

	task automatic exp_take(output rec_t r);
		r = exp_mem[exp_rd % EXP_D];
		exp_rd++;
	endtask

	task automatic join_ready(input int s);
		if (rlen < SLOTS) begin
			rdy[rlen] = s;
			rlen++;
		end
		place[s] = PL_READY;
	endtask

	// advance the model by one accepted transfer; queue any record it yields
	task automatic sched_step(input logic mode, input logic [2:0] sl, input logic [7:0] v,
			input logic lst);
		rec_t r;
		int c, i, best, s;
		logic [VAL_W-1:0] bv, b;
		logic busy;
		r = '{default: '0};
		if (mode == MODE_LOAD) begin
			c = bcnt[sl];
			if (!(place[sl] == PL_EMPTY || place[sl] == PL_LOADING) || c >= MAX_BURSTS
					|| v == 0 || (lst && c[0])) begin
				r.kind = KIND_REJECT;
				r.slot = sl;
				exp_put(r);
			end else begin
				bstore[sl][c] = v;
				bcnt[sl] = c + 1;
				if (lst) join_ready(sl);
				else place[sl] = PL_LOADING;
			end
		end else begin
			if (!cpu_on && rlen > 0) begin
				best = 0;
				bv = next_len(rdy[0]);
				for (i = 1; i < rlen; i++) begin
					b = next_len(rdy[i]);
					if (b < bv) begin
						bv = b;
						best = i;
					end
				end
				s = rdy[best];
				for (i = best; i + 1 < rlen; i++) rdy[i] = rdy[i+1];
				rlen--;
				if (!ran[s]) begin
					respc[s] = waitc[s];
					ran[s] = 1'b1;
				end
				cpu_rem = bv;
				if (bptr[s] < MAX_BURSTS) bptr[s]++;
				run_slot = s;
				cpu_on = 1'b1;
				place[s] = PL_RUNNING;
			end
			if (cpu_on) begin
				if (cpu_rem > 0) cpu_rem--;
				cpuc[run_slot] = sat16(cpuc[run_slot]);
			end
			for (s = 0; s < SLOTS; s++) begin
				if (place[s] == PL_IO) begin
					if (io_rem[s] > 0) io_rem[s]--;
					ioc[s] = sat16(ioc[s]);
					if (io_rem[s] == 0) join_ready(s);
				end
			end
			for (i = 0; i < rlen; i++) waitc[rdy[i]] = sat16(waitc[rdy[i]]);
			if (cpu_on && cpu_rem == 0) begin
				s = run_slot;
				cpu_on = 1'b0;
				if (bptr[s] < bcnt[s]) begin
					io_rem[s] = next_len(s);
					bptr[s]++;
					place[s] = PL_IO;
				end else begin
					place[s] = PL_FINISHED;
					busy = 1'b0;
					for (i = 0; i < SLOTS; i++)
						if (place[i] inside {PL_READY, PL_RUNNING, PL_IO}) busy = 1'b1;
					r.kind = KIND_FINISH;
					r.slot = s;
					r.wait_t = waitc[s];
					r.resp = respc[s];
					r.cpu = cpuc[s];
					r.io = ioc[s];
					r.turn = TURN_W'(waitc[s]) + TURN_W'(cpuc[s]) + TURN_W'(ioc[s]);
					r.all_fin = !busy;
					exp_put(r);
				end
			end
		end
	endtask

	task automatic mism(input string what);
		errors++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// result side: check each transfer, then decide on back-pressure
	always @(posedge clk) begin
		rec_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (exp_wr == exp_rd) begin
				mism("unexpected result");
			end else begin
				exp_take(e);
				if (m_tuser !== e.kind) mism($sformatf("kind %0b exp %0b", m_tuser, e.kind));
				if (m_tdata[2:0] !== e.slot)
					mism($sformatf("slot %0d exp %0d", m_tdata[2:0], e.slot));
				if (m_tdata[18:3] !== e.wait_t)
					mism($sformatf("wait %0d exp %0d", m_tdata[18:3], e.wait_t));
				if (m_tdata[34:19] !== e.resp)
					mism($sformatf("response %0d exp %0d", m_tdata[34:19], e.resp));
				if (m_tdata[50:35] !== e.cpu)
					mism($sformatf("cpu %0d exp %0d", m_tdata[50:35], e.cpu));
				if (m_tdata[66:51] !== e.io)
					mism($sformatf("io %0d exp %0d", m_tdata[66:51], e.io));
				if (m_tdata[84:67] !== e.turn)
					mism($sformatf("turnaround %0d exp %0d", m_tdata[84:67], e.turn));
				if (m_tdata[85] !== e.all_fin)
					mism($sformatf("all_finished %0b exp %0b", m_tdata[85], e.all_fin));
				if (m_tdata[87:86] !== 2'b00) mism("pad bits set");
			end
			if (idle_en) stall = $urandom_range(0, 9);
		end
		if (long_hold > 0) begin
			long_hold <= long_hold - 1;
			m_tready <= 1'b0;
		end else if (stall > 0) begin
			stall = stall - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// one input transfer; valid stays high across back-to-back transfers
	task automatic send(input logic mode, input logic [2:0] sl, input logic [7:0] v,
			input logic lst);
		int gap;
		gap = idle_en ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {5'b0, v, sl};
		s_tlast  <= lst;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sched_step(mode, sl, v, lst);
		items++;
	endtask

	task automatic tick();
		send(1'b1, 3'($urandom), 8'($urandom), 1'($urandom));
	endtask

	// sender pause until every record has arrived, then let the core settle
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (exp_wr != exp_rd) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// zero length, even-length close, idle ticks, a one-process run, loads after finish
	task automatic test_directed();
		send(MODE_LOAD, 3'd7, 8'd0, 1'b0);
		tick();
		tick();
		send(MODE_LOAD, 3'd7, 8'd255, 1'b0);
		send(MODE_LOAD, 3'd7, 8'd4, 1'b1);
		send(MODE_LOAD, 3'd7, 8'd1, 1'b0);
		send(MODE_LOAD, 3'd7, 8'd2, 1'b1);
		send(MODE_LOAD, 3'd7, 8'd9, 1'b0);
		repeat (300) tick();
		send(MODE_LOAD, 3'd7, 8'd3, 1'b1);
		drain();
	endtask

	// slot 6 fills its list without a close and stays loading
	task automatic test_full_list();
		repeat (MAX_BURSTS) send(MODE_LOAD, 3'd6, 8'($urandom_range(1, 255)), 1'b0);
		send(MODE_LOAD, 3'd6, 8'd5, 1'b1);
		tick();
		drain();
	endtask

	// receiver holds off while rejects pile up behind the result register
	task automatic test_backpressure();
		long_hold = 400;
		repeat (20) send(MODE_LOAD, 3'($urandom_range(6, 7)), 8'($urandom), 1'($urandom));
		drain();
	endtask

	// well-formed burst lists on slots 0..5 with ticks, plus rejected noise
	task automatic test_random();
		int plan [RAND_SLOTS];
		int sent [RAND_SLOTS];
		int s, k, pend;
		logic [7:0] v;
		bit busy;
		for (s = 0; s < RAND_SLOTS; s++) begin
			plan[s] = 2 * $urandom_range(0, 15) + 1;
			sent[s] = 0;
		end
		do begin
			if ($urandom_range(0, 199) == 0) idle_en = !idle_en;
			pend = 0;
			for (s = 0; s < RAND_SLOTS; s++) if (sent[s] < plan[s]) pend++;
			k = $urandom_range(0, 99);
			if (k < 8) begin
				// noise: always rejected, so the plans stay valid
				s = $urandom_range(0, 7);
				if (s >= RAND_SLOTS || sent[s] >= plan[s])
					send(MODE_LOAD, 3'(s), 8'($urandom), 1'($urandom));
				else if (sent[s][0])
					send(MODE_LOAD, 3'(s), 8'($urandom_range(1, 255)), 1'b1);
				else
					send(MODE_LOAD, 3'(s), 8'd0, 1'($urandom));
			end else if (pend > 0 && k < 40) begin
				do s = $urandom_range(0, RAND_SLOTS - 1); while (sent[s] >= plan[s]);
				// mostly short bursts, now and then a long one
				v = ($urandom_range(0, 19) < 19) ? 8'($urandom_range(1, 15))
					: 8'($urandom_range(16, 255));
				sent[s]++;
				send(MODE_LOAD, 3'(s), v, sent[s] == plan[s]);
			end else begin
				tick();
			end
			busy = pend > 0 || cpu_on || rlen > 0;
			for (s = 0; s < SLOTS; s++) if (place[s] == PL_IO) busy = 1'b1;
		end while (busy || items < 1700);
		idle_en = 1'b1;
		drain();
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		items = 0;
		exp_wr = 0;
		exp_rd = 0;
		idle_en = 1'b1;
		long_hold = 0;
		stall = 0;
		for (int s = 0; s < SLOTS; s++) begin
			bcnt[s] = 0;
			bptr[s] = 0;
			place[s] = PL_EMPTY;
			io_rem[s] = '0;
			waitc[s] = '0;
			respc[s] = '0;
			cpuc[s] = '0;
			ioc[s] = '0;
			ran[s] = 1'b0;
			rdy[s] = 0;
		end
		rlen = 0;
		run_slot = 0;
		cpu_rem = '0;
		cpu_on = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tlast = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_list();
		test_backpressure();
		test_random();
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
